/* rtl/qselu_pkg.sv */
package qselu_pkg;

  // Number format and expansion length
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned EXP_TERMS    = 5;
  localparam int unsigned HORNER_STEPS = EXP_TERMS - 1;

  // Field and register widths
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned COEF_W     = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Datapath widths
  localparam int unsigned XW    = CODE_W + SCALE_W;             // dequantized magnitude
  localparam int unsigned PW    = FRAC_BITS + 1;                // values in 0..ONE
  localparam int unsigned L2E_W = 31;
  localparam int unsigned LN2_W = 16;
  localparam int unsigned NW    = XW + L2E_W - 30 - FRAC_BITS;  // integer part of a*log2(e)
  localparam int unsigned SUBW  = NW + LN2_W;
  localparam int unsigned PPW   = COEF_W + XW;                  // lambda * x
  localparam int unsigned YW    = PPW - FRAC_BITS + 1;          // |y| before requantize
  localparam int unsigned ALPW  = 2 * COEF_W;                   // alpha * lambda
  localparam int unsigned ALW   = ALPW - FRAC_BITS + 1;
  localparam int unsigned MMW   = ALW + PW;                     // al * (ONE - e)
  localparam int unsigned RPW   = YW + SCALE_W;                 // |y| * out_scale_recip
  localparam int unsigned VW    = RPW + 1;                      // requantize accumulator
  localparam int unsigned QW    = VW - 2 * FRAC_BITS;

  // Fixed-point constants
  localparam logic [PW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
  localparam longint unsigned LN2_Q30   = 64'd744261118;
  localparam longint unsigned LN2_F =
      (LN2_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic [CODE_W-1:0] CODE_MAX = 8'd255;

  // Register reset values
  localparam logic [SCALE_W-1:0] IN_SCALE_RST  = 24'd65536;
  localparam logic [CODE_W-1:0]  IN_ZERO_RST   = 8'd0;
  localparam logic [SCALE_W-1:0] OUT_RECIP_RST = 24'd65536;
  localparam logic [CODE_W-1:0]  OUT_ZERO_RST  = 8'd0;
  localparam logic [COEF_W-1:0]  ALPHA_RST     = 20'd109658;
  localparam logic [COEF_W-1:0]  LAMBDA_RST    = 20'd68862;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_SCALE  = 3'd0,
    REG_IN_ZERO   = 3'd1,
    REG_OUT_RECIP = 3'd2,
    REG_OUT_ZERO  = 3'd3,
    REG_ALPHA     = 3'd4,
    REG_LAMBDA    = 3'd5
  } qselu_reg_e;

  typedef struct packed {
    logic [SCALE_W-1:0] in_scale;
    logic [CODE_W-1:0]  in_zero;
    logic [SCALE_W-1:0] out_recip;
    logic [CODE_W-1:0]  out_zero;
    logic [COEF_W-1:0]  alpha;
    logic [COEF_W-1:0]  lambda;
  } cfg_t;

  // Per-beat control and the positive-branch result riding along the exp path
  typedef struct packed {
    logic          vld;
    logic          last;
    logic          negx;
    logic [YW-1:0] ypos;
  } side_t;

endpackage

/* rtl/quantized_selu_activation_u8_unit.sv */
// A result beat passes through 18 register stages after its input beat is accepted
// (front end, range reduction, four two-stage Horner steps, exp scaling, requantize).
// Throughput: one beat per cycle; all stages advance together and hold while
// the output beat is stalled.
// Reset: clears every valid bit and loads the register defaults; no clearing pass.
module quantized_selu_activation_u8_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [qselu_pkg::CODE_W-1:0]      in_code_i,
  input  logic                              in_last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [qselu_pkg::CODE_W-1:0]      out_code_o,
  output logic                              out_last_o,
  input  logic                              cfg_we_i,
  input  logic [qselu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [qselu_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import qselu_pkg::*;

  cfg_t            cfg_q;
  logic            en;
  side_t           fr_side, ex_side;
  logic [XW-1:0]   fr_a;
  logic [NW-1:0]   fr_n;
  logic [SUBW-1:0] fr_sub;
  logic [MMW-1:0]  ex_mm;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_scale  <= IN_SCALE_RST;
      cfg_q.in_zero   <= IN_ZERO_RST;
      cfg_q.out_recip <= OUT_RECIP_RST;
      cfg_q.out_zero  <= OUT_ZERO_RST;
      cfg_q.alpha     <= ALPHA_RST;
      cfg_q.lambda    <= LAMBDA_RST;
    end else if (cfg_we_i) begin
      case (qselu_reg_e'(cfg_idx_i))
        REG_IN_SCALE:  cfg_q.in_scale  <= cfg_wdata_i[SCALE_W-1:0];
        REG_IN_ZERO:   cfg_q.in_zero   <= cfg_wdata_i[CODE_W-1:0];
        REG_OUT_RECIP: cfg_q.out_recip <= cfg_wdata_i[SCALE_W-1:0];
        REG_OUT_ZERO:  cfg_q.out_zero  <= cfg_wdata_i[CODE_W-1:0];
        REG_ALPHA:     cfg_q.alpha     <= cfg_wdata_i[COEF_W-1:0];
        REG_LAMBDA:    cfg_q.lambda    <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless the output beat is held
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  qselu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .code_i (in_code_i),
    .last_i (in_last_i),
    .cfg_i  (cfg_q),
    .side_o (fr_side),
    .a_o    (fr_a),
    .n_o    (fr_n),
    .sub_o  (fr_sub)
  );

  qselu_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .side_i (fr_side),
    .a_i    (fr_a),
    .n_i    (fr_n),
    .sub_i  (fr_sub),
    .side_o (ex_side),
    .mm_o   (ex_mm)
  );

  qselu_requant u_requant (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .side_i (ex_side),
    .mm_i   (ex_mm),
    .vld_o  (out_valid_o),
    .code_o (out_code_o),
    .last_o (out_last_o)
  );

endmodule

/* rtl/qselu_front.sv */
module qselu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [qselu_pkg::CODE_W-1:0]  code_i,
  input  logic                          last_i,
  input  qselu_pkg::cfg_t               cfg_i,
  output qselu_pkg::side_t              side_o,
  output logic [qselu_pkg::XW-1:0]      a_o,
  output logic [qselu_pkg::NW-1:0]      n_o,
  output logic [qselu_pkg::SUBW-1:0]    sub_o
);
  import qselu_pkg::*;

  localparam int unsigned NPW = XW + L2E_W;

  logic              neg_d;
  logic [CODE_W-1:0] dmag_d;
  logic [XW-1:0]     x_d;
  logic              vld1_q, last1_q, neg1_q;
  logic [XW-1:0]     x1_q;

  logic              negx2_d;
  logic [PPW-1:0]    pp2_d;
  logic [NPW-1:0]    nprod_d;
  logic              vld2_q, last2_q, negx2_q;
  logic [PPW-1:0]    pp2_q;
  logic [XW-1:0]     a2_q;
  logic [NW-1:0]     n2_q;

  logic [YW-1:0]     ypos_d;
  logic [SUBW-1:0]   sub_d;
  logic              vld3_q, last3_q, negx3_q;
  logic [YW-1:0]     ypos3_q;
  logic [XW-1:0]     a3_q;
  logic [NW-1:0]     n3_q;
  logic [SUBW-1:0]   sub3_q;

  // Dequantize: sign and magnitude of (code - zero) * scale
  always_comb begin
    neg_d  = code_i < cfg_i.in_zero;
    dmag_d = neg_d ? cfg_i.in_zero - code_i : code_i - cfg_i.in_zero;
    x_d    = XW'(dmag_d) * XW'(cfg_i.in_scale);
  end

  // Scale by lambda and by log2(e) in parallel
  always_comb begin
    negx2_d = neg1_q && (x1_q != '0);
    pp2_d   = PPW'(cfg_i.lambda) * PPW'(x1_q);
    nprod_d = NPW'(x1_q) * NPW'(LOG2E_Q30);
  end

  // Round the positive result, form n * ln2
  always_comb begin
    ypos_d = YW'(pp2_q >> FRAC_BITS) + YW'(pp2_q[FRAC_BITS-1]);
    sub_d  = SUBW'(n2_q) * SUBW'(LN2_F);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last1_q <= last_i;
      neg1_q  <= neg_d;
      x1_q    <= x_d;
      last2_q <= last1_q;
      negx2_q <= negx2_d;
      pp2_q   <= pp2_d;
      a2_q    <= x1_q;
      n2_q    <= nprod_d[NPW-1 -: NW];
      last3_q <= last2_q;
      negx3_q <= negx2_q;
      ypos3_q <= ypos_d;
      a3_q    <= a2_q;
      n3_q    <= n2_q;
      sub3_q  <= sub_d;
    end
  end

  assign side_o = '{vld: vld3_q, last: last3_q, negx: negx3_q, ypos: ypos3_q};
  assign a_o    = a3_q;
  assign n_o    = n3_q;
  assign sub_o  = sub3_q;

endmodule

/* rtl/qselu_exp.sv */
module qselu_exp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  qselu_pkg::cfg_t               cfg_i,
  input  qselu_pkg::side_t              side_i,
  input  logic [qselu_pkg::XW-1:0]      a_i,
  input  logic [qselu_pkg::NW-1:0]      n_i,
  input  logic [qselu_pkg::SUBW-1:0]    sub_i,
  output qselu_pkg::side_t              side_o,
  output logic [qselu_pkg::MMW-1:0]     mm_o
);
  import qselu_pkg::*;

  logic [SUBW-1:0] diff_d;
  logic [PW-1:0]   r_d;

  side_t           sd_a [HORNER_STEPS+1];
  logic [PW-1:0]   r_a  [HORNER_STEPS+1];
  logic [NW-1:0]   n_a  [HORNER_STEPS+1];
  logic [PW-1:0]   q_a  [HORNER_STEPS];

  logic [PW-1:0]   pf_d, sh_d, rb_d, e_d, om_d;
  logic [PW-1:0]   om_q;
  side_t           sdf_q, sdm_q;
  logic [ALPW-1:0] alp_q;
  logic [ALW-1:0]  al_q;
  logic [MMW-1:0]  mm_q;

  // Range reduction: r = a - n*ln2, clamped to 0..ONE
  always_comb begin
    diff_d = '0;
    if (SUBW'(a_i) > sub_i) begin
      diff_d = SUBW'(a_i) - sub_i;
    end
    if (diff_d > SUBW'(ONE)) begin
      r_d = ONE;
    end else begin
      r_d = diff_d[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_a[0] <= '0;
    end else if (en_i) begin
      sd_a[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_a[0] <= r_d;
      n_a[0] <= n_i;
    end
  end

  // Horner steps for exp(-r): each multiplies, then rounds and divides by the term index
  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
    localparam int unsigned Div  = HORNER_STEPS - k;
    localparam int unsigned Rnd  = Div / 2;
    localparam int unsigned Sh   = PW + $clog2(Div);
    localparam longint unsigned Mul = ((64'd1 << Sh) + Div - 1) / Div;
    localparam int unsigned MulW = Sh + 1;

    logic [PW-1:0]        p_d;
    logic [2*PW-1:0]      m_d, m_q;
    side_t                sd_q;
    logic [PW-1:0]        r_q;
    logic [NW-1:0]        n_q;
    logic [PW-1:0]        t_d;
    logic [PW+MulW-1:0]   qp_d;

    if (k == 0) begin : g_first
      assign p_d = ONE;
    end else begin : g_next
      assign p_d = (q_a[k-1] > ONE) ? '0 : ONE - q_a[k-1];
    end

    assign m_d = (2*PW)'(r_a[k]) * (2*PW)'(p_d);

    // Round the product, add half the divisor, divide by reciprocal multiply
    always_comb begin
      t_d  = PW'(m_q >> FRAC_BITS) + PW'(m_q[FRAC_BITS-1]) + PW'(Rnd);
      qp_d = (PW+MulW)'(t_d) * (PW+MulW)'(Mul);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sd_q      <= '0;
        sd_a[k+1] <= '0;
      end else if (en_i) begin
        sd_q      <= sd_a[k];
        sd_a[k+1] <= sd_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q       <= m_d;
        r_q       <= r_a[k];
        n_q       <= n_a[k];
        q_a[k]    <= qp_d[Sh +: PW];
        r_a[k+1]  <= r_q;
        n_a[k+1]  <= n_q;
      end
    end
  end

  // Scale by 2^-n with rounding, form ONE - e
  always_comb begin
    pf_d = (q_a[HORNER_STEPS-1] > ONE) ? '0 : ONE - q_a[HORNER_STEPS-1];
    sh_d = pf_d >> n_a[HORNER_STEPS];
    rb_d = pf_d >> (n_a[HORNER_STEPS] - NW'(1));
    if (n_a[HORNER_STEPS] == '0) begin
      e_d = pf_d;
    end else if (n_a[HORNER_STEPS] > NW'(FRAC_BITS + 1)) begin
      e_d = '0;
    end else begin
      e_d = sh_d + PW'(rb_d[0]);
    end
    if (e_d > ONE) begin
      e_d = ONE;
    end
    om_d = ONE - e_d;
  end

  // Track alpha*lambda from the registers; the user must change them only while idle (not enforced here)
  always_ff @(posedge clk_i) begin
    alp_q <= ALPW'(cfg_i.alpha) * ALPW'(cfg_i.lambda);
    al_q  <= ALW'(alp_q >> FRAC_BITS) + ALW'(alp_q[FRAC_BITS-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdf_q <= '0;
      sdm_q <= '0;
    end else if (en_i) begin
      sdf_q <= sd_a[HORNER_STEPS];
      sdm_q <= sdf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      om_q <= om_d;
      mm_q <= MMW'(al_q) * MMW'(om_q);
    end
  end

  assign side_o = sdm_q;
  assign mm_o   = mm_q;

endmodule

/* rtl/qselu_requant.sv */
module qselu_requant (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  qselu_pkg::cfg_t               cfg_i,
  input  qselu_pkg::side_t              side_i,
  input  logic [qselu_pkg::MMW-1:0]     mm_i,
  output logic                          vld_o,
  output logic [qselu_pkg::CODE_W-1:0]  code_o,
  output logic                          last_o
);
  import qselu_pkg::*;

  logic [YW-1:0]     yneg_d, y_d;
  logic              vld1_q, last1_q, neg1_q;
  logic [YW-1:0]     y1_q;
  logic              vld2_q, last2_q, neg2_q;
  logic [RPW-1:0]    prod2_q;
  logic [VW-1:0]     zterm_d, pext_d, v_d;
  logic              vld3_q, last3_q;
  logic [VW-1:0]     v3_q;
  logic [VW-1:0]     rs_d;
  logic [QW-1:0]     q_d;
  logic [CODE_W-1:0] code_d;
  logic              vld4_q, last4_q;
  logic [CODE_W-1:0] code4_q;

  // Round the negative branch and pick the branch result
  always_comb begin
    yneg_d = YW'(mm_i >> FRAC_BITS) + YW'(mm_i[FRAC_BITS-1]);
    y_d    = side_i.negx ? yneg_d : side_i.ypos;
  end

  // Add or subtract against the zero-point term; a negative total gives zero
  always_comb begin
    zterm_d = VW'(cfg_i.out_zero) << (2 * FRAC_BITS);
    pext_d  = VW'(prod2_q);
    if (!neg2_q) begin
      v_d = zterm_d + pext_d;
    end else if (pext_d <= zterm_d) begin
      v_d = zterm_d - pext_d;
    end else begin
      v_d = '0;
    end
  end

  // Round half away from zero and saturate
  always_comb begin
    rs_d = v3_q + (VW'(1) << (2 * FRAC_BITS - 1));
    q_d  = rs_d[VW-1 -: QW];
    if (q_d > QW'(CODE_MAX)) begin
      code_d = CODE_MAX;
    end else begin
      code_d = q_d[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= side_i.vld;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last1_q <= side_i.last;
      neg1_q  <= side_i.negx;
      y1_q    <= y_d;
      last2_q <= last1_q;
      neg2_q  <= neg1_q;
      prod2_q <= RPW'(y1_q) * RPW'(cfg_i.out_recip);
      last3_q <= last2_q;
      v3_q    <= v_d;
      last4_q <= last3_q;
      code4_q <= code_d;
    end
  end

  assign vld_o  = vld4_q;
  assign code_o = code4_q;
  assign last_o = last4_q;

endmodule

/* rtl/qselu_checker.sv */
module qselu_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [qselu_pkg::CODE_W-1:0]      in_code_i,
  input logic                              in_last_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [qselu_pkg::CODE_W-1:0]      out_code_o,
  input logic                              out_last_o,
  input logic                              cfg_we_i,
  input logic [qselu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [qselu_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_code_o) && $stable(out_last_o))
    else $error("stalled output beat changed");

  // Stall the input exactly while the output beat is held
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output hold");

  // Drop all beats in reset
  a_rst_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) && !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind quantized_selu_activation_u8_unit qselu_checker u_qselu_checker (.*);
